// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

    // Default number of entries the queue holds.
    localparam int DEPTH_DEF = 16;

    // Width of element and priority values.
    localparam int DATA_W = 32;

    // Width of the reported entry count.
    localparam int COUNT_W = 5;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One stored pair.
    typedef struct packed {
        logic signed [DATA_W-1:0] elem;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    // One result, handed from the engine to the output stage.
    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] popped_elem;
        logic signed [DATA_W-1:0] popped_prio;
        logic                     found;
        logic signed [DATA_W-1:0] top_elem;
        logic signed [DATA_W-1:0] top_prio;
        logic [COUNT_W-1:0]       count;
    } t_result;

    // True when priority p goes ahead of a held priority q under the given order.
    function automatic logic ranks(
        input logic                     mode,
        input logic signed [DATA_W-1:0] p,
        input logic signed [DATA_W-1:0] q
    );
        ranks = mode ? (q <= p) : (p <= q);
    endfunction

endpackage

// ===== rtl/core/spq_mem.sv =====
module spq_mem
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEF,
    localparam int IW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Command channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    input  logic [DATA_W-1:0] i_elem_in,
    input  logic [DATA_W-1:0] i_prio_in,
    // Order register write
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    // Memory ports
    output logic              o_mem_we,
    output logic [IW-1:0]     o_mem_waddr,
    output t_entry            o_mem_wdata,
    output logic              o_mem_re,
    output logic [IW-1:0]     o_mem_raddr,
    input  t_entry            i_mem_rdata,
    // Result handoff
    output logic              o_res_valid,
    input  logic              i_res_take,
    output t_result           o_res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_PLACE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state         r_state, n_state;
    t_cmd           r_cmd, n_cmd;
    t_entry         r_new, n_new;
    logic [IW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_count, n_count;
    t_entry         r_top, n_top;
    logic           r_mode, n_mode;
    t_status        r_status, n_status;
    t_entry         r_pop, n_pop;
    logic           r_found, n_found;
    logic           r_to_front, n_to_front;

    t_entry         in_entry;
    logic [IW-1:0]  last_idx;
    logic           at_last;
    logic           push_up;

    assign in_entry = '{elem: i_elem_in, prio: i_prio_in};
    assign last_idx = IW'(r_count - CW'(1));
    assign at_last  = (CW'(r_idx) == (r_count - CW'(1)));

    // A push moves the word up when the new pair goes ahead of it. Once the pair
    // is known to go ahead of both the last and the first entry, it goes to the
    // serving end, so every word moves up even if the held entries are unsorted.
    assign push_up = ranks(r_mode, r_new.prio, i_mem_rdata.prio) || (r_to_front && !at_last);

    // Sequencer: each scan cycle uses the word read last cycle, writes one word
    // (push/pop) and issues the next read. Write and read addresses never meet.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_new       = r_new;
        n_idx       = r_idx;
        n_count     = r_count;
        n_top       = r_top;
        n_status    = r_status;
        n_pop       = r_pop;
        n_found     = r_found;
        n_to_front  = r_to_front;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = r_new;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = t_cmd'(i_command);
                    n_new    = in_entry;
                    n_status = ST_OK;
                    n_pop    = '0;
                    n_found  = 1'b0;
                    n_state  = S_EMIT;
                    case (t_cmd'(i_command))
                        CMD_PUSH: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                o_mem_we    = 1'b1;
                                o_mem_wdata = in_entry;
                                n_top       = in_entry;
                                n_count     = CW'(1);
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = last_idx;
                                n_idx       = last_idx;
                                n_to_front  = ranks(r_mode, in_entry.prio, r_top.prio);
                                n_state     = S_SCAN;
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_pop = r_top;
                                if (r_count == CW'(1)) begin
                                    n_count = '0;
                                end else begin
                                    o_mem_re    = 1'b1;
                                    o_mem_raddr = IW'(1);
                                    n_idx       = IW'(1);
                                    n_state     = S_SCAN;
                                end
                            end
                        end
                        CMD_SEARCH: begin
                            if (r_count != '0) begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = '0;
                                n_idx       = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                case (r_cmd)
                    CMD_PUSH: begin
                        // Move entries up while the new pair goes ahead of them.
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_idx + IW'(1);
                        if (push_up) begin
                            o_mem_wdata = i_mem_rdata;
                            if (r_idx == '0) begin
                                n_state = S_PLACE;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = r_idx - IW'(1);
                                n_idx       = r_idx - IW'(1);
                            end
                        end else begin
                            o_mem_wdata = r_new;
                            n_count     = r_count + CW'(1);
                            n_state     = S_EMIT;
                        end
                    end
                    CMD_POP: begin
                        // Move each entry one slot toward the serving end.
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_idx - IW'(1);
                        o_mem_wdata = i_mem_rdata;
                        if (r_idx == IW'(1)) begin
                            n_top = i_mem_rdata;
                        end
                        if (at_last) begin
                            n_count = r_count - CW'(1);
                            n_state = S_EMIT;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = r_idx + IW'(1);
                            n_idx       = r_idx + IW'(1);
                        end
                    end
                    CMD_SEARCH: begin
                        if (i_mem_rdata.elem == r_new.elem) begin
                            n_found = 1'b1;
                        end
                        if (at_last) begin
                            n_state = S_EMIT;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = r_idx + IW'(1);
                            n_idx       = r_idx + IW'(1);
                        end
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end

            S_PLACE: begin
                // The new pair goes to the serving end.
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                o_mem_wdata = r_new;
                n_top       = r_new;
                n_count     = r_count + CW'(1);
                n_state     = S_EMIT;
            end

            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Order register transfer.
    assign n_mode = i_cfg_valid ? i_cfg_data : r_mode;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_mode  <= n_mode;
        end
    end

    // Working payload.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_new      <= n_new;
        r_idx      <= n_idx;
        r_top      <= n_top;
        r_status   <= n_status;
        r_pop      <= n_pop;
        r_found    <= n_found;
        r_to_front <= n_to_front;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);

    // Result assembly; the top pair reads as zero when the queue is empty.
    always_comb begin
        o_res.status      = r_status;
        o_res.popped_elem = r_pop.elem;
        o_res.popped_prio = r_pop.prio;
        o_res.found       = r_found;
        o_res.top_elem    = (r_count != '0) ? r_top.elem : '0;
        o_res.top_prio    = (r_count != '0) ? r_top.prio : '0;
        o_res.count       = COUNT_W'(r_count);
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds the queue depth");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("memory read and write hit the same entry");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_idx) < r_count))
        else $error("scan index outside the held entries");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_status == ST_FULL) |-> (r_count == CW'(QUEUE_DEPTH)))
        else $error("full status reported on a queue that is not full");
`endif

endmodule

// ===== rtl/core/spq_out.sv =====
module spq_out
    import spq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Result handoff
    input  logic              i_res_valid,
    output logic              o_res_take,
    input  t_result           i_res,
    // Result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_popped_elem,
    output logic [DATA_W-1:0] o_popped_prio,
    output logic              o_found,
    output logic [DATA_W-1:0] o_top_elem,
    output logic [DATA_W-1:0] o_top_prio,
    output logic [COUNT_W-1:0] o_count
);

    logic    r_valid;
    t_result r_res;

    // The register takes a new result when empty or when its result leaves.
    assign o_res_take = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_take) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_take && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_status      = r_res.status;
    assign o_popped_elem = r_res.popped_elem;
    assign o_popped_prio = r_res.popped_prio;
    assign o_found       = r_res.found;
    assign o_top_elem    = r_res.top_elem;
    assign o_top_prio    = r_res.top_prio;
    assign o_count       = r_res.count;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted priority queue of (element, priority) pairs.
// Commands arrive on the input channel (i_in_valid, o_in_stall): push, pop or
// search, with an element and a priority. Each command gives one result on the
// output channel (o_out_valid, i_out_stall): status, popped pair, search flag,
// the pair served next and the entry count after the command.
// The order register (i_cfg_valid, o_cfg_ready, i_cfg_data) picks lowest-first
// (0) or highest-first (1); write it only while no command is in flight.
// The entries live in one memory with a registered read; a command walks
// it one entry per cycle: a search reads all, a pop shifts the rest and a
// push moves entries from the far end until its slot. A push into an empty
// queue, full/empty errors and unused commands skip the walk. A new command
// is taken the cycle after the result enters the output register, so the
// memory walk sets the rate while the receiver does not stall.
// Reset empties the queue and selects lowest-first; no clearing pass is needed.
// While the receiver stalls, the output register holds its result; one more
// command can complete behind it, after which the input channel stalls.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Command channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [DATA_W-1:0]  i_elem_in,
    input  logic [DATA_W-1:0]  i_prio_in,
    // Order register
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    // Result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [DATA_W-1:0]  o_popped_elem,
    output logic [DATA_W-1:0]  o_popped_prio,
    output logic               o_found,
    output logic [DATA_W-1:0]  o_top_elem,
    output logic [DATA_W-1:0]  o_top_prio,
    output logic [COUNT_W-1:0] o_count
);

    localparam int IW = $clog2(QUEUE_DEPTH);

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic          res_valid;
    logic          res_take;
    t_result       res;

    // The order register accepts a write in any cycle.
    assign o_cfg_ready = 1'b1;

    spq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    spq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_elem_in   (i_elem_in),
        .i_prio_in   (i_prio_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    spq_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (res_valid),
        .o_res_take    (res_take),
        .i_res         (res),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_popped_elem (o_popped_elem),
        .o_popped_prio (o_popped_prio),
        .o_found       (o_found),
        .o_top_elem    (o_top_elem),
        .o_top_prio    (o_top_prio),
        .o_count       (o_count)
    );

endmodule

// ===== dv/sorted_priority_queue_test.sv =====
`timescale 1ns / 100ps

module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 128;
    localparam int MAX_PRINTED = 100;

    // Command code that the block must treat as a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Leanings of the random command mix.
    localparam int LEAN_FILL = 0;
    localparam int LEAN_DRAIN = 1;
    localparam int LEAN_MIX = 2;

    localparam logic signed [DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] PRIO_MAX = 32'sh7fff_ffff;

    // One command as it appears on the input channel.
    typedef struct {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] elem;
        logic signed [DATA_W-1:0] prio;
    } t_request;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_command = CMD_PUSH;
    logic [DATA_W-1:0]  i_elem_in = '0;
    logic [DATA_W-1:0]  i_prio_in = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic [DATA_W-1:0]  o_popped_elem;
    logic [DATA_W-1:0]  o_popped_prio;
    logic               o_found;
    logic [DATA_W-1:0]  o_top_elem;
    logic [DATA_W-1:0]  o_top_prio;
    logic [COUNT_W-1:0] o_count;

    sorted_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_elem_in    (i_elem_in),
        .i_prio_in    (i_prio_in),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_popped_elem(o_popped_elem),
        .o_popped_prio(o_popped_prio),
        .o_found      (o_found),
        .o_top_elem   (o_top_elem),
        .o_top_prio   (o_top_prio),
        .o_count      (o_count)
    );

    // Shadow copy of the queue contents and the order register.
    t_entry      shadow_entries [DEPTH];
    int          shadow_count = 0;
    logic        shadow_high_first = 1'b0;

    t_request    pending_requests[$];
    t_result     awaited_results[$];
    t_request    on_port;
    logic signed [DATA_W-1:0] pushed_elems[$];

    int          in_flight = 0;
    int          error_count = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    // Clock generation.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // True when priority p is served ahead of a held priority q.
    function automatic logic serves_ahead(
        input logic signed [DATA_W-1:0] p,
        input logic signed [DATA_W-1:0] q
    );
        return shadow_high_first ? (p >= q) : (p <= q);
    endfunction

    // Apply one command to the shadow queue and return the result it yields.
    function automatic t_result next_queue_result(input t_request req);
        t_result r;
        int      pos;
        int      cur;
        int      i;
        r = '0;
        r.status = ST_OK;
        if (req.cmd == CMD_PUSH) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // Insert after the first slot, scanning from the far end, that outranks it.
                if (shadow_count == 0) begin
                    pos = 0;
                end else if (!serves_ahead(req.prio, shadow_entries[shadow_count - 1].prio)) begin
                    pos = shadow_count;
                end else if (serves_ahead(req.prio, shadow_entries[0].prio)) begin
                    pos = 0;
                end else begin
                    cur = shadow_count - 1;
                    while (cur > 0 && serves_ahead(req.prio, shadow_entries[cur].prio))
                        cur--;
                    pos = cur + 1;
                end
                for (i = shadow_count; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i - 1];
                shadow_entries[pos].elem = req.elem;
                shadow_entries[pos].prio = req.prio;
                shadow_count++;
            end
        end else if (req.cmd == CMD_POP) begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped_elem = shadow_entries[0].elem;
                r.popped_prio = shadow_entries[0].prio;
                for (i = 1; i < shadow_count; i++)
                    shadow_entries[i - 1] = shadow_entries[i];
                shadow_count--;
            end
        end else if (req.cmd == CMD_SEARCH) begin
            for (i = 0; i < shadow_count; i++) begin
                if (shadow_entries[i].elem == req.elem)
                    r.found = 1'b1;
            end
        end
        if (shadow_count != 0) begin
            r.top_elem = shadow_entries[0].elem;
            r.top_prio = shadow_entries[0].prio;
        end
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    // Print one mismatch line (up to a cap) and count it.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic compare_field(
        input string             name,
        input logic [DATA_W-1:0] got,
        input logic [DATA_W-1:0] want
    );
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // Hand one command to the driver.
    task automatic queue_request(input logic [1:0] cmd, input logic signed [DATA_W-1:0] elem,
                                 input logic signed [DATA_W-1:0] prio);
        t_request req;
        req.cmd = cmd;
        req.elem = elem;
        req.prio = prio;
        if (cmd == CMD_PUSH) begin
            pushed_elems.push_back(elem);
            if (pushed_elems.size() > 32)
                void'(pushed_elems.pop_front());
        end
        pending_requests.push_back(req);
        in_flight++;
    endtask

    function automatic logic signed [DATA_W-1:0] extreme_value();
        case ($urandom_range(0, 3))
            0: return PRIO_MIN;
            1: return PRIO_MAX;
            2: return -1;
            default: return 0;
        endcase
    endfunction

    // Priorities lean toward a narrow range so that ties are common.
    function automatic logic signed [DATA_W-1:0] random_prio();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return int'($urandom_range(0, 8)) - 4;
        else if (roll < 60)
            return int'($urandom_range(0, 2000)) - 1000;
        else if (roll < 70)
            return extreme_value();
        return $urandom();
    endfunction

    // Elements come often from a small pool so that searches hit.
    function automatic logic signed [DATA_W-1:0] random_elem();
        if ($urandom_range(0, 99) < 55)
            return int'($urandom_range(0, 15)) - 8;
        return $urandom();
    endfunction

    task automatic queue_random_request(input int lean);
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        logic [1:0]  cmd;
        logic signed [DATA_W-1:0] elem;
        push_pct = (lean == LEAN_FILL) ? 65 : (lean == LEAN_DRAIN) ? 20 : 40;
        pop_pct = (lean == LEAN_FILL) ? 20 : (lean == LEAN_DRAIN) ? 65 : 40;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            cmd = CMD_PUSH;
        else if (roll < push_pct + pop_pct)
            cmd = CMD_POP;
        else if (roll < 97)
            cmd = CMD_SEARCH;
        else
            cmd = CMD_UNUSED;
        elem = random_elem();
        // Most searches look for something pushed recently.
        if (cmd == CMD_SEARCH && pushed_elems.size() != 0 && $urandom_range(0, 99) < 60)
            elem = pushed_elems[$urandom_range(0, pushed_elems.size() - 1)];
        queue_request(cmd, elem, random_prio());
    endtask

    // Write the order register; called just after a rising edge.
    task automatic write_order(input logic high_first);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= high_first;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_high_first = high_first;
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued command has produced its result, then a short pause.
    task automatic wait_drained(input int tail);
        do @(posedge i_clk); while (in_flight != 0);
        repeat (tail) @(posedge i_clk);
    endtask

    // Command driver: one transfer per accepted item, random gaps in between.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                awaited_results.push_back(next_queue_result(on_port));
            end
            if (i_in_valid && o_in_stall) begin
                // Stalled: the payload holds.
            end else if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
                send_gap = $urandom_range(0, 11);
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                on_port = pending_requests.pop_front();
                i_in_valid <= 1'b1;
                i_command <= on_port.cmd;
                i_elem_in <= on_port.elem;
                i_prio_in <= on_port.prio;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall generation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing awaited",
                                              results_seen));
                end else begin
                    want = awaited_results.pop_front();
                    in_flight--;
                    compare_field("status", o_status, want.status);
                    compare_field("popped_elem", o_popped_elem, want.popped_elem);
                    compare_field("popped_prio", o_popped_prio, want.popped_prio);
                    compare_field("found", o_found, want.found);
                    compare_field("top_elem", o_top_elem, want.top_elem);
                    compare_field("top_prio", o_top_prio, want.top_prio);
                    compare_field("count", o_count, want.count);
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 11);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        int phase;
        int n;
        int lean;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_order(1'b0);

        // Directed part, lowest value first: empty-queue cases.
        send_idle_pct = 10;
        stall_pct = 10;
        queue_request(CMD_POP, 0, 0);
        queue_request(CMD_SEARCH, 0, 0);
        queue_request(CMD_UNUSED, PRIO_MAX, PRIO_MIN);
        // Placement: first entry, served last, served first, tie, and a middle slot.
        queue_request(CMD_PUSH, 10, 0);
        queue_request(CMD_PUSH, PRIO_MAX, PRIO_MAX);
        queue_request(CMD_PUSH, PRIO_MIN, PRIO_MIN);
        queue_request(CMD_PUSH, 11, 0);
        queue_request(CMD_PUSH, -1, -5);
        // Fill the queue, then push once more to hit the full case.
        for (n = 0; n < DEPTH - 5; n++)
            queue_request(CMD_PUSH, $urandom(), int'($urandom_range(0, 8)) - 4);
        queue_request(CMD_PUSH, 99, 1);
        queue_request(CMD_SEARCH, 11, 0);
        queue_request(CMD_SEARCH, 32'sh1234_5678, 0);
        queue_request(CMD_UNUSED, 0, 0);
        queue_request(CMD_POP, 0, 0);
        queue_request(CMD_POP, 0, 0);
        wait_drained(4);

        // Random phases; the order flips each phase while entries are still held.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1) begin
                send_idle_pct = 0;
                stall_pct = 0;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                stall_pct = 35;
            end else if (phase == 3) begin
                send_idle_pct = 35;
                stall_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(3, 20);
                stall_pct = $urandom_range(3, 20);
            end
            write_order((phase % 2) == 0);
            lean = LEAN_MIX;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 24 == 0)
                    lean = $urandom_range(LEAN_FILL, LEAN_MIX);
                queue_random_request(lean);
            end
            wait_drained(4);
        end

        repeat (24) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
